FILE: design/rcf_pkg.sv
// Shared constants and types of the rectangle and circle fill engine.
`timescale 1ns / 1ps
package rcf_pkg;

  localparam int unsigned MaxWidth  = 64;
  localparam int unsigned MaxHeight = 64;
  localparam int unsigned Depth     = MaxWidth * MaxHeight;
  localparam int unsigned AddrW     = $clog2(Depth);
  localparam int unsigned CoordW    = 6;
  localparam int unsigned SizeW     = 7;
  localparam int unsigned PixelW    = 32;
  localparam int unsigned PosW      = 16;
  localparam int unsigned ExtW      = 15;
  localparam int unsigned BoundW    = PosW + 2;
  localparam int unsigned DeltaW    = 17;
  localparam int unsigned SqW       = 32;
  localparam int unsigned RsqW      = 2 * ExtW;

  typedef enum logic [1:0] {
    OpClear  = 2'd0,
    OpRect   = 2'd1,
    OpCircle = 2'd2,
    OpRead   = 2'd3
  } opcode_e;

  typedef enum logic {
    CfgFbWidth  = 1'b0,
    CfgFbHeight = 1'b1
  } cfg_idx_e;

endpackage

FILE: design/rect_circle_fill_engine_top.sv
// Rectangle and circle fill engine over a 64 by 64 frame store of 32-bit pixels.
//
//   channel  | direction | handshake                  | payload
//   ---------+-----------+----------------------------+------------------------------------
//   command  | in        | in_valid_i / in_ready_o    | opcode, color, pos_x/y, extent_a/b,
//            |           |                            | pixel_x/y
//   result   | out       | out_valid_o / out_ready_i  | pixel_data (reads only)
//   config   | in        | cfg_we_i, no wait          | cfg_index_i, cfg_wdata_i
//
// A fill visits one pixel of its clipped box per cycle and writes the ones it covers
// through the single write port of the frame store; a clear covers the whole W*H area.
// A read passes through request, registered memory read and output register.
// Reset clears control state only; the frame store holds garbage until written.
// A read waits in its request state while an earlier result is not yet taken; fills
// and further commands are accepted while a result sits in the output register.
`timescale 1ns / 1ps
module rect_circle_fill_engine_top (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic                              in_valid_i,
  output logic                              in_ready_o,
  input  logic [1:0]                        opcode_i,
  input  logic [rcf_pkg::PixelW-1:0]        color_i,
  input  logic signed [rcf_pkg::PosW-1:0]   pos_x_i,
  input  logic signed [rcf_pkg::PosW-1:0]   pos_y_i,
  input  logic [rcf_pkg::ExtW-1:0]          extent_a_i,
  input  logic [rcf_pkg::ExtW-1:0]          extent_b_i,
  input  logic [rcf_pkg::CoordW-1:0]        pixel_x_i,
  input  logic [rcf_pkg::CoordW-1:0]        pixel_y_i,
  output logic                              out_valid_o,
  input  logic                              out_ready_i,
  output logic [rcf_pkg::PixelW-1:0]        pixel_data_o,
  input  logic                              cfg_we_i,
  input  logic                              cfg_index_i,
  input  logic [rcf_pkg::SizeW-1:0]         cfg_wdata_i
);

  typedef enum logic [5:0] {
    StIdle   = 6'b000001,
    StSetup  = 6'b000010,
    StScan   = 6'b000100,
    StDrain  = 6'b001000,
    StRdReq  = 6'b010000,
    StRdData = 6'b100000
  } state_e;

  localparam int unsigned MacW = rcf_pkg::CoordW + rcf_pkg::SizeW;

  state_e state_q, state_d;

  // Configuration.
  logic [rcf_pkg::SizeW-1:0] fb_width_q, fb_height_q;
  logic [rcf_pkg::SizeW-1:0] eff_w, eff_h;

  // Captured command.
  rcf_pkg::opcode_e                  cmd_op_q;
  logic [rcf_pkg::PixelW-1:0]        cmd_color_q;
  logic signed [rcf_pkg::PosW-1:0]   cmd_px_q, cmd_py_q;
  logic [rcf_pkg::ExtW-1:0]          cmd_ea_q, cmd_eb_q;
  logic [rcf_pkg::CoordW-1:0]        cmd_rx_q, cmd_ry_q;

  // Scan box and position.
  logic [rcf_pkg::SizeW-1:0]  x0_d, x1_d, y0_d, y1_d;
  logic [rcf_pkg::SizeW-1:0]  x0_q, x1_q, y1_q;
  logic [rcf_pkg::CoordW-1:0] x_q, y_q;
  logic [rcf_pkg::RsqW-1:0]   rsq_q;
  logic                       box_ok;
  logic                       x_last, y_last;

  // Pixel pipeline.
  logic                              v1_q, v2_q;
  logic [rcf_pkg::AddrW-1:0]         addr1_q, addr2_q;
  logic signed [rcf_pkg::DeltaW-1:0] dx1_q, dy1_q;
  logic [rcf_pkg::SqW-1:0]           sqx_q, sqy_q;
  logic [MacW-1:0]                   scan_mac;
  logic signed [rcf_pkg::DeltaW-1:0] dx_d, dy_d;
  logic signed [2*rcf_pkg::DeltaW-1:0] sqx_full, sqy_full;
  logic [rcf_pkg::SqW:0]             dist_sq;
  logic                              is_circle;

  // Frame store and read path.
  logic [rcf_pkg::PixelW-1:0] mem [rcf_pkg::Depth];
  logic                       mem_we, mem_re;
  logic [rcf_pkg::PixelW-1:0] rd_data_q;
  logic [MacW-1:0]            rd_mac;
  logic                       rd_in_q;
  logic                       out_valid_q;
  logic [rcf_pkg::PixelW-1:0] out_data_q;

  logic signed [rcf_pkg::BoundW-1:0] px_s, py_s, ea_s, eb_s;
  logic signed [rcf_pkg::BoundW-1:0] lo_x, hi_x, lo_y, hi_y;

  function automatic logic [rcf_pkg::SizeW-1:0] clamp_box(
    input logic signed [rcf_pkg::BoundW-1:0] v,
    input logic [rcf_pkg::SizeW-1:0]         lim
  );
    logic signed [rcf_pkg::BoundW-1:0] lim_s;
    lim_s = $signed({{(rcf_pkg::BoundW-rcf_pkg::SizeW){1'b0}}, lim});
    if (v < 0) begin
      return '0;
    end else if (v > lim_s) begin
      return lim;
    end else begin
      return v[rcf_pkg::SizeW-1:0];
    end
  endfunction

  assign eff_w = (fb_width_q > rcf_pkg::SizeW'(rcf_pkg::MaxWidth)) ?
                 rcf_pkg::SizeW'(rcf_pkg::MaxWidth) : fb_width_q;
  assign eff_h = (fb_height_q > rcf_pkg::SizeW'(rcf_pkg::MaxHeight)) ?
                 rcf_pkg::SizeW'(rcf_pkg::MaxHeight) : fb_height_q;

  assign in_ready_o   = (state_q == StIdle);
  assign out_valid_o  = out_valid_q;
  assign pixel_data_o = out_data_q;
  assign is_circle    = (cmd_op_q == rcf_pkg::OpCircle);

  // Configuration writes.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      fb_width_q  <= rcf_pkg::SizeW'(rcf_pkg::MaxWidth);
      fb_height_q <= rcf_pkg::SizeW'(rcf_pkg::MaxHeight);
    end else if (cfg_we_i) begin
      case (rcf_pkg::cfg_idx_e'(cfg_index_i))
        rcf_pkg::CfgFbWidth:  fb_width_q  <= cfg_wdata_i;
        rcf_pkg::CfgFbHeight: fb_height_q <= cfg_wdata_i;
        default: ;
      endcase
    end
  end

  // Command capture.
  always_ff @(posedge clk_i) begin
    if (in_valid_i && in_ready_o) begin
      cmd_op_q    <= rcf_pkg::opcode_e'(opcode_i);
      cmd_color_q <= color_i;
      cmd_px_q    <= pos_x_i;
      cmd_py_q    <= pos_y_i;
      cmd_ea_q    <= extent_a_i;
      cmd_eb_q    <= extent_b_i;
      cmd_rx_q    <= pixel_x_i;
      cmd_ry_q    <= pixel_y_i;
    end
  end

  // Box bounds: floor of the low edge, ceiling of the high edge, clipped to the area.
  always_comb begin
    px_s = $signed({{(rcf_pkg::BoundW-rcf_pkg::PosW){cmd_px_q[rcf_pkg::PosW-1]}}, cmd_px_q});
    py_s = $signed({{(rcf_pkg::BoundW-rcf_pkg::PosW){cmd_py_q[rcf_pkg::PosW-1]}}, cmd_py_q});
    ea_s = $signed({{(rcf_pkg::BoundW-rcf_pkg::ExtW){1'b0}}, cmd_ea_q});
    eb_s = $signed({{(rcf_pkg::BoundW-rcf_pkg::ExtW){1'b0}}, cmd_eb_q});
    lo_x = is_circle ? (px_s - ea_s) : px_s;
    lo_y = is_circle ? (py_s - ea_s) : py_s;
    hi_x = px_s + ea_s + rcf_pkg::BoundW'(15);
    hi_y = (is_circle ? (py_s + ea_s) : (py_s + eb_s)) + rcf_pkg::BoundW'(15);
    if (cmd_op_q == rcf_pkg::OpClear) begin
      x0_d = '0;
      y0_d = '0;
      x1_d = eff_w;
      y1_d = eff_h;
    end else begin
      x0_d = clamp_box(lo_x >>> 4, rcf_pkg::SizeW'(rcf_pkg::MaxWidth));
      y0_d = clamp_box(lo_y >>> 4, rcf_pkg::SizeW'(rcf_pkg::MaxHeight));
      x1_d = clamp_box(hi_x >>> 4, eff_w);
      y1_d = clamp_box(hi_y >>> 4, eff_h);
    end
    box_ok = (x0_d < x1_d) && (y0_d < y1_d);
  end

  assign x_last = ({1'b0, x_q} + rcf_pkg::SizeW'(1)) == x1_q;
  assign y_last = ({1'b0, y_q} + rcf_pkg::SizeW'(1)) == y1_q;

  always_comb begin
    state_d = state_q;
    mem_re  = 1'b0;
    case (state_q)
      StIdle: begin
        if (in_valid_i) begin
          state_d = (rcf_pkg::opcode_e'(opcode_i) == rcf_pkg::OpRead) ? StRdReq : StSetup;
        end
      end
      StSetup:  state_d = box_ok ? StScan : StIdle;
      StScan: begin
        if (x_last && y_last) begin
          state_d = StDrain;
        end
      end
      StDrain: begin
        if (!v1_q && !v2_q) begin
          state_d = StIdle;
        end
      end
      StRdReq: begin
        if (!out_valid_q || out_ready_i) begin
          mem_re  = 1'b1;
          state_d = StRdData;
        end
      end
      StRdData: state_d = StIdle;
      default:  state_d = StIdle;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= StIdle;
    end else begin
      state_q <= state_d;
    end
  end

  // Scan position walks the box row by row.
  always_ff @(posedge clk_i) begin
    if (state_q == StSetup) begin
      x0_q  <= x0_d;
      x1_q  <= x1_d;
      y1_q  <= y1_d;
      x_q   <= x0_d[rcf_pkg::CoordW-1:0];
      y_q   <= y0_d[rcf_pkg::CoordW-1:0];
      rsq_q <= cmd_ea_q * cmd_ea_q;
    end else if (state_q == StScan) begin
      if (x_last) begin
        x_q <= x0_q[rcf_pkg::CoordW-1:0];
        y_q <= y_q + rcf_pkg::CoordW'(1);
      end else begin
        x_q <= x_q + rcf_pkg::CoordW'(1);
      end
    end
  end

  // Stage one: address and pixel-centre offsets; stage two: squares.
  assign scan_mac = MacW'(y_q) * MacW'(eff_w) + MacW'(x_q);
  assign dx_d = $signed({{(rcf_pkg::DeltaW-rcf_pkg::CoordW-4){1'b0}}, x_q, 4'b1000})
              - $signed({cmd_px_q[rcf_pkg::PosW-1], cmd_px_q});
  assign dy_d = $signed({{(rcf_pkg::DeltaW-rcf_pkg::CoordW-4){1'b0}}, y_q, 4'b1000})
              - $signed({cmd_py_q[rcf_pkg::PosW-1], cmd_py_q});
  assign sqx_full = dx1_q * dx1_q;
  assign sqy_full = dy1_q * dy1_q;
  assign dist_sq  = {1'b0, sqx_q} + {1'b0, sqy_q};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q <= 1'b0;
      v2_q <= 1'b0;
    end else begin
      v1_q <= (state_q == StScan);
      v2_q <= v1_q;
    end
  end

  always_ff @(posedge clk_i) begin
    addr1_q <= scan_mac[rcf_pkg::AddrW-1:0];
    dx1_q   <= dx_d;
    dy1_q   <= dy_d;
    addr2_q <= addr1_q;
    sqx_q   <= sqx_full[rcf_pkg::SqW-1:0];
    sqy_q   <= sqy_full[rcf_pkg::SqW-1:0];
  end

  assign mem_we = v2_q && (!is_circle || (dist_sq <= (rcf_pkg::SqW+1)'(rsq_q)));
  assign rd_mac = MacW'(cmd_ry_q) * MacW'(eff_w) + MacW'(cmd_rx_q);

  always_ff @(posedge clk_i) begin
    if (mem_we) begin
      mem[addr2_q] <= cmd_color_q;
    end
    if (mem_re) begin
      rd_data_q <= mem[rd_mac[rcf_pkg::AddrW-1:0]];
    end
  end

  always_ff @(posedge clk_i) begin
    if (mem_re) begin
      rd_in_q <= ({1'b0, cmd_rx_q} < eff_w) && ({1'b0, cmd_ry_q} < eff_h);
    end
    if (state_q == StRdData) begin
      out_data_q <= rd_in_q ? rd_data_q : '0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (state_q == StRdData) begin
      out_valid_q <= 1'b1;
    end else if (out_ready_i) begin
      out_valid_q <= 1'b0;
    end
  end

endmodule

FILE: design/rcf_checker.sv
// Port-level checks of the fill engine, bound to its top level.
`timescale 1ns / 1ps
module rcf_checker (
  input logic                              clk_i,
  input logic                              rst_ni,
  input logic                              in_valid_i,
  input logic                              in_ready_o,
  input logic [1:0]                        opcode_i,
  input logic                              out_valid_o,
  input logic                              out_ready_i,
  input logic [rcf_pkg::PixelW-1:0]        pixel_data_o
);

  logic in_xfer;
  assign in_xfer = in_valid_i && in_ready_o;

  // A held result keeps its value until it is transferred.
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=> out_valid_o && $stable(pixel_data_o))
    else $error("result changed or dropped while stalled");

  // Every command leaves the engine busy in the cycle after it is accepted.
  a_busy_after_cmd: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_xfer |=> !in_ready_o)
    else $error("command accepted back to back");

  // A read into an empty output register delivers its result once it has passed the request and data states.
  a_read_latency: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_xfer && (opcode_i == rcf_pkg::OpRead) && !out_valid_o |-> ##3 out_valid_o)
    else $error("read result late");

  // Clear and fill commands give no result.
  a_fill_silent: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_xfer && (opcode_i != rcf_pkg::OpRead) && !out_valid_o
    |=> !out_valid_o ##1 !out_valid_o)
    else $error("result produced by a fill command");

endmodule

bind rect_circle_fill_engine_top rcf_checker u_rcf_checker (.*);
